FILE: rtl/plwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package plwc_pkg;

  localparam int unsigned FreqW  = 30;
  localparam int unsigned ShiftW = 16;
  localparam int unsigned RefW   = 25;
  localparam int unsigned PfdW   = 24;
  localparam int unsigned FracW  = 19;
  localparam int unsigned QuoW   = FreqW + FracW;
  localparam int unsigned DevW   = 24;
  localparam int unsigned StepW  = 16;
  localparam int unsigned NumStages = QuoW;

  localparam logic [FreqW-1:0] FreqLimitB1 = 30'd705000000;
  localparam logic [FreqW-1:0] FreqLimitB2 = 30'd525000000;
  localparam logic [FreqW-1:0] FreqLimitB3 = 30'd353000000;
  localparam logic [FreqW-1:0] FreqLimitB4 = 30'd239000000;
  localparam logic [FreqW-1:0] FreqLimitB5 = 30'd177000000;

  localparam logic [RefW-1:0] RefReset = 25'd26000000;
  localparam logic [15:0] DevHz = 16'd1300;
  localparam logic [3:0] SynthSel = 4'd8;

  // Division by three through a reciprocal: exact for any value below 2^RefW.
  localparam int unsigned Div3Shift = 26;
  localparam logic [RefW-1:0] Div3Mult = 25'd22369622;

  typedef enum logic [2:0] {
    BAND_NONE = 3'd0,
    BAND_1    = 3'd1,
    BAND_2    = 3'd2,
    BAND_3    = 3'd3,
    BAND_4    = 3'd4,
    BAND_5    = 3'd5
  } band_e;

  typedef struct packed {
    logic [FreqW-1:0]  freq_hz;
    logic [ShiftW-1:0] shift_hz;
  } in_t;

  typedef struct packed {
    logic [3:0]       band_word;
    logic [7:0]       integer_divider;
    logic [19:0]      frac_word;
    logic [StepW-1:0] channel_step;
    logic [DevW-1:0]  deviation_word;
    logic             out_of_range;
  } out_t;

  typedef struct packed {
    band_e            band;
    logic             too_high;
    logic [FreqW-1:0] freq;
    logic [PfdW-1:0]  pfd;
    logic [PfdW-1:0]  rem;
    logic [QuoW-1:0]  quo;
    logic [DevW-1:0]  dev_lo;
    logic [RefW-1:0]  dev_rem;
    logic [DevW-1:0]  dev_q;
    logic             dev_sat;
    logic [RefW-1:0]  step_rem;
    logic [StepW-1:0] step_q;
    logic             step_sat;
  } pipe_t;

  function automatic logic [4:0] div_of(band_e band);
    logic [4:0] d;
    unique case (band)
      BAND_2:  d = 5'd8;
      BAND_3:  d = 5'd12;
      BAND_4:  d = 5'd16;
      BAND_5:  d = 5'd24;
      default: d = 5'd6;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/fractional_n_pll_word_calc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Fractional-N synthesizer word calculator.
// An item on the input channel carries a carrier frequency and an FSK shift in
// Hz; for each item one result item leaves on the output channel with the band
// word, integer divider, 20-bit fractional word, channel step, deviation word
// and an out-of-range flag. Both channels use valid/ready.
// The reference frequency register is written through cfg_we_i/cfg_data_i and
// takes effect for items accepted afterwards; write it only while idle.
// One stage picks the band and forms the phase detector rate, 49 stages
// each retire one quotient bit of the restoring divider (30 integer bits
// of freq/pfd followed by 19 fraction bits, with the channel step and
// deviation divisions running alongside), and one stage saturates and
// registers the result. A new item is accepted every cycle but in a stall:
// when the receiver stalls with a result waiting, the whole pipeline holds in
// place and in_ready_o drops; nothing is lost or repeated.
// Reset empties the pipeline and loads the reference register with 26 MHz.
module fractional_n_pll_word_calc_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [plwc_pkg::RefW-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire plwc_pkg::in_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output plwc_pkg::out_t                     out_data_o
);

  logic [plwc_pkg::RefW-1:0] ref_q;
  logic en;
  logic            valid_s [0:plwc_pkg::NumStages];
  plwc_pkg::pipe_t pipe_s  [0:plwc_pkg::NumStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= plwc_pkg::RefReset;
    end else if (cfg_we_i) begin
      ref_q <= cfg_data_i;
    end
  end

  // The pipeline advances as a whole whenever the output register is free or
  // being taken.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  plwc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .ref_i   (ref_q),
    .valid_o (valid_s[0]),
    .pipe_o  (pipe_s[0])
  );

  for (genvar s = 0; s < plwc_pkg::NumStages; s++) begin : g_stage
    plwc_div_stage #(
      .Step (s)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_s[s]),
      .pipe_i  (pipe_s[s]),
      .ref_i   (ref_q),
      .valid_o (valid_s[s+1]),
      .pipe_o  (pipe_s[s+1])
    );
  end

  plwc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_s[plwc_pkg::NumStages]),
    .pipe_i  (pipe_s[plwc_pkg::NumStages]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule
`default_nettype wire

FILE: rtl/plwc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module plwc_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire plwc_pkg::in_t    data_i,
  input  wire logic [plwc_pkg::RefW-1:0] ref_i,
  output logic                  valid_o,
  output plwc_pkg::pipe_t       pipe_o
);

  plwc_pkg::band_e band;
  logic [4:0] div;
  logic [plwc_pkg::RefW-1:0] div3_a;
  logic [2*plwc_pkg::RefW-1:0] div3_p;
  logic [plwc_pkg::PfdW-1:0] pfd;
  logic [20:0] step_p;
  logic [plwc_pkg::RefW-1:0] step_init;
  logic [15:0] dev_p;
  logic [plwc_pkg::RefW-1:0] dev_init;
  plwc_pkg::pipe_t pipe_d, pipe_q;
  logic valid_q;

  always_comb begin
    if (data_i.freq_hz < plwc_pkg::FreqLimitB5) begin
      band = plwc_pkg::BAND_5;
    end else if (data_i.freq_hz < plwc_pkg::FreqLimitB4) begin
      band = plwc_pkg::BAND_4;
    end else if (data_i.freq_hz < plwc_pkg::FreqLimitB3) begin
      band = plwc_pkg::BAND_3;
    end else if (data_i.freq_hz < plwc_pkg::FreqLimitB2) begin
      band = plwc_pkg::BAND_2;
    end else if (data_i.freq_hz < plwc_pkg::FreqLimitB1) begin
      band = plwc_pkg::BAND_1;
    end else begin
      band = plwc_pkg::BAND_NONE;
    end
    div = plwc_pkg::div_of(band);

    // The phase detector rate is 2*ref/div; dividers with a factor of three
    // go through the reciprocal multiply.
    case (band)
      plwc_pkg::BAND_3: div3_a = ref_i >> 1;
      plwc_pkg::BAND_5: div3_a = ref_i >> 2;
      default:          div3_a = ref_i;
    endcase
    div3_p = {{plwc_pkg::RefW{1'b0}}, div3_a} * {{plwc_pkg::RefW{1'b0}}, plwc_pkg::Div3Mult};
    case (band)
      plwc_pkg::BAND_2: pfd = plwc_pkg::PfdW'(ref_i >> 2);
      plwc_pkg::BAND_4: pfd = plwc_pkg::PfdW'(ref_i >> 3);
      default:          pfd = div3_p[plwc_pkg::Div3Shift +: plwc_pkg::PfdW];
    endcase

    step_p    = 21'(div) * 21'(data_i.shift_hz);
    step_init = plwc_pkg::RefW'({step_p, 2'b00});
    dev_p     = 16'(div) * plwc_pkg::DevHz;
    dev_init  = plwc_pkg::RefW'(dev_p[15:5]);

    pipe_d          = '0;
    pipe_d.band     = band;
    pipe_d.too_high = (band == plwc_pkg::BAND_NONE);
    pipe_d.freq     = data_i.freq_hz;
    pipe_d.pfd      = pfd;
    pipe_d.dev_lo   = {dev_p[4:0], 19'd0};
    pipe_d.dev_rem  = dev_init;
    pipe_d.dev_sat  = (dev_init >= ref_i);
    pipe_d.step_rem = step_init;
    pipe_d.step_sat = (step_init >= ref_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule
`default_nettype wire

FILE: rtl/plwc_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module plwc_div_stage #(
  parameter int unsigned Step = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire plwc_pkg::pipe_t  pipe_i,
  input  wire logic [plwc_pkg::RefW-1:0] ref_i,
  output logic                  valid_o,
  output plwc_pkg::pipe_t       pipe_o
);

  localparam int unsigned FreqIdx = (Step < plwc_pkg::FreqW) ? plwc_pkg::FreqW - 1 - Step : 0;
  localparam int unsigned DevIdx  = (Step < plwc_pkg::DevW) ? plwc_pkg::DevW - 1 - Step : 0;

  logic in_bit;
  logic [plwc_pkg::PfdW:0] r2;
  logic ge;
  logic [plwc_pkg::RefW:0] d2;
  logic dge;
  logic [plwc_pkg::RefW:0] s2;
  logic sge;
  plwc_pkg::pipe_t pipe_d, pipe_q;
  logic valid_q;

  always_comb begin
    pipe_d = pipe_i;

    // One restoring step of freq/pfd, which then runs on into the fraction.
    in_bit = (Step < plwc_pkg::FreqW) ? pipe_i.freq[FreqIdx] : 1'b0;
    r2 = {pipe_i.rem, in_bit};
    ge = (r2 >= {1'b0, pipe_i.pfd});
    pipe_d.rem = ge ? plwc_pkg::PfdW'(r2 - {1'b0, pipe_i.pfd}) : r2[plwc_pkg::PfdW-1:0];
    pipe_d.quo = {pipe_i.quo[plwc_pkg::QuoW-2:0], ge};

    d2  = {pipe_i.dev_rem, (Step < plwc_pkg::DevW) ? pipe_i.dev_lo[DevIdx] : 1'b0};
    dge = (d2 >= {1'b0, ref_i});
    if (Step < plwc_pkg::DevW) begin
      pipe_d.dev_rem = dge ? plwc_pkg::RefW'(d2 - {1'b0, ref_i}) : d2[plwc_pkg::RefW-1:0];
      pipe_d.dev_q   = {pipe_i.dev_q[plwc_pkg::DevW-2:0], dge};
    end

    s2  = {pipe_i.step_rem, 1'b0};
    sge = (s2 >= {1'b0, ref_i});
    if (Step < plwc_pkg::StepW) begin
      pipe_d.step_rem = sge ? plwc_pkg::RefW'(s2 - {1'b0, ref_i}) : s2[plwc_pkg::RefW-1:0];
      pipe_d.step_q   = {pipe_i.step_q[plwc_pkg::StepW-2:0], sge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule
`default_nettype wire

FILE: rtl/plwc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module plwc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire plwc_pkg::pipe_t  pipe_i,
  output logic                  valid_o,
  output plwc_pkg::out_t        data_o
);

  logic [plwc_pkg::FreqW-1:0] q;
  logic [plwc_pkg::FracW-1:0] fr;
  logic q_zero, q_big, pfd_zero;
  logic [plwc_pkg::FreqW-1:0] q_m1;
  plwc_pkg::out_t out_d, out_q;
  logic valid_q;

  always_comb begin
    q        = pipe_i.quo[plwc_pkg::QuoW-1:plwc_pkg::FracW];
    fr       = pipe_i.quo[plwc_pkg::FracW-1:0];
    q_zero   = (q == '0);
    q_big    = (q > plwc_pkg::FreqW'(256));
    pfd_zero = (pipe_i.pfd == '0);
    q_m1     = q - plwc_pkg::FreqW'(1);

    out_d.band_word = plwc_pkg::SynthSel + 4'(pipe_i.band);
    if (pfd_zero) begin
      out_d.integer_divider = '0;
      out_d.frac_word       = '0;
      out_d.channel_step    = '0;
      out_d.deviation_word  = '0;
    end else begin
      out_d.integer_divider = q_zero ? 8'd0 : (q_big ? 8'hFF : q_m1[7:0]);
      // For 0 < q <= 256 the integer part carries one pfd into the fraction.
      out_d.frac_word       = q_big ? 20'hFFFFF : {!q_zero, fr};
      out_d.channel_step    = pipe_i.step_sat ? '1 : pipe_i.step_q;
      out_d.deviation_word  = pipe_i.dev_sat ? '1 : pipe_i.dev_q;
    end
    out_d.out_of_range = pipe_i.too_high | pfd_zero | q_zero | q_big
                         | pipe_i.step_sat | pipe_i.dev_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = out_q;

endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned Latency = 51;
  localparam int unsigned RandomItems = 1200;
  localparam longint unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [plwc_pkg::RefW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  plwc_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  plwc_pkg::out_t out_data_o;

  fractional_n_pll_word_calc_core u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // The reference frequency as the bench believes the block holds it.
  logic [plwc_pkg::RefW-1:0] ref_hz = plwc_pkg::RefReset;
  plwc_pkg::out_t tuning_words_q[$];
  int unsigned mismatches = 0;
  longint unsigned cycle_count = 0;

  // Receiver behavior, steered by the stimulus process.
  bit rx_calm = 1'b0;
  int unsigned rx_hold_cycles = 0;

  // Computes the synthesizer words for one request at the current reference.
  function automatic plwc_pkg::out_t tuning_words(logic [plwc_pkg::FreqW-1:0] freq,
                                                  logic [plwc_pkg::ShiftW-1:0] shift);
    plwc_pkg::out_t r;
    longint unsigned f, rf, dv, pfd, q, n, fr, st, dv_w;
    plwc_pkg::band_e band;
    bit flag;
    f = freq;
    rf = ref_hz;
    flag = 1'b0;
    n = 0; fr = 0; st = 0; dv_w = 0;
    // Each lower threshold overrides the one above it.
    if (f < plwc_pkg::FreqLimitB1) begin band = plwc_pkg::BAND_1; dv = 6; end
    else begin band = plwc_pkg::BAND_NONE; dv = 6; flag = 1'b1; end
    if (f < plwc_pkg::FreqLimitB2) begin band = plwc_pkg::BAND_2; dv = 8; end
    if (f < plwc_pkg::FreqLimitB3) begin band = plwc_pkg::BAND_3; dv = 12; end
    if (f < plwc_pkg::FreqLimitB4) begin band = plwc_pkg::BAND_4; dv = 16; end
    if (f < plwc_pkg::FreqLimitB5) begin band = plwc_pkg::BAND_5; dv = 24; end
    pfd = (2 * rf) / dv;
    if (pfd == 0) begin
      flag = 1'b1;
    end else begin
      q = f / pfd;
      if (q == 0) begin
        flag = 1'b1;
      end else if (q - 1 > 255) begin
        n = 255;
        flag = 1'b1;
      end else begin
        n = q - 1;
      end
      fr = ((f - n * pfd) << 19) / pfd;
      if (fr > 64'hFFFFF) begin fr = 64'hFFFFF; flag = 1'b1; end
      st = (64'd524288 * dv * shift) / (2 * rf);
      if (st > 64'hFFFF) begin st = 64'hFFFF; flag = 1'b1; end
      dv_w = (64'd524288 * dv * plwc_pkg::DevHz) / rf;
      if (dv_w > 64'hFFFFFF) begin dv_w = 64'hFFFFFF; flag = 1'b1; end
    end
    r.band_word = 4'(band) + plwc_pkg::SynthSel;
    r.integer_divider = n[7:0];
    r.frac_word = fr[19:0];
    r.channel_step = st[15:0];
    r.deviation_word = dv_w[23:0];
    r.out_of_range = flag;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
  endtask

  // Offers one item and waits for it to be accepted. Valid stays high into the
  // next call when there is no idle cycle between items.
  task automatic send_request(plwc_pkg::in_t item, bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < 7) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // A directed row optionally carries the full result read straight off the
  // special-case rules, checked against the predictor that always supplies it.
  task automatic send_checked(plwc_pkg::in_t item, bit may_idle, bit has_known,
                              plwc_pkg::out_t known);
    plwc_pkg::out_t want;
    want = tuning_words(item.freq_hz, item.shift_hz);
    if (has_known && want !== known) report_mismatch("directed table entry", 0, 1);
    tuning_words_q.push_back(want);
    send_request(item, may_idle);
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tuning_words_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_ref(logic [plwc_pkg::RefW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ref_hz = value;
    @(posedge clk_i);
  endtask

  function automatic plwc_pkg::in_t random_request();
    plwc_pkg::in_t it;
    int unsigned pick;
    pick = $urandom_range(9);
    case (pick)
      0: it.freq_hz = plwc_pkg::FreqW'($urandom);
      1: it.freq_hz = plwc_pkg::FreqW'($urandom_range(50000000));
      2: it.freq_hz = plwc_pkg::FreqW'($urandom_range(1073741823, 700000000));
      // Near a band threshold, on either side.
      3: begin
        case ($urandom_range(4))
          0: it.freq_hz = plwc_pkg::FreqLimitB1;
          1: it.freq_hz = plwc_pkg::FreqLimitB2;
          2: it.freq_hz = plwc_pkg::FreqLimitB3;
          3: it.freq_hz = plwc_pkg::FreqLimitB4;
          default: it.freq_hz = plwc_pkg::FreqLimitB5;
        endcase
        it.freq_hz = it.freq_hz + plwc_pkg::FreqW'($urandom_range(4))
                     - plwc_pkg::FreqW'(2);
      end
      // Mostly ordinary radio frequencies inside the bands.
      default: it.freq_hz = plwc_pkg::FreqW'($urandom_range(704999999, 100000000));
    endcase
    it.shift_hz = ($urandom_range(3) == 0) ? plwc_pkg::ShiftW'($urandom)
                                           : plwc_pkg::ShiftW'($urandom_range(5000));
    return it;
  endfunction

  // Receiver: random stalls, an optional long hold-off, and calm stretches.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_ready_i <= rx_calm ? 1'b1 : ($urandom_range(99) >= 7);
      end
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    plwc_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tuning_words_q.size() == 0) begin
        report_mismatch("unexpected result item", 1, 0);
      end else begin
        want = tuning_words_q.pop_front();
        if (out_data_o.band_word !== want.band_word)
          report_mismatch("band_word", out_data_o.band_word, want.band_word);
        if (out_data_o.integer_divider !== want.integer_divider)
          report_mismatch("integer_divider", out_data_o.integer_divider, want.integer_divider);
        if (out_data_o.frac_word !== want.frac_word)
          report_mismatch("frac_word", out_data_o.frac_word, want.frac_word);
        if (out_data_o.channel_step !== want.channel_step)
          report_mismatch("channel_step", out_data_o.channel_step, want.channel_step);
        if (out_data_o.deviation_word !== want.deviation_word)
          report_mismatch("deviation_word", out_data_o.deviation_word, want.deviation_word);
        if (out_data_o.out_of_range !== want.out_of_range)
          report_mismatch("out_of_range", out_data_o.out_of_range, want.out_of_range);
      end
    end
  end

  // Watchdog: a hung block ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("fractional_n_pll_word_calc_core regression: fail");
      $finish;
    end
  end

  typedef struct {
    logic [plwc_pkg::FreqW-1:0]  freq;
    logic [plwc_pkg::ShiftW-1:0] shift;
    bit                          has_known;
    plwc_pkg::out_t              known;
  } directed_row_t;

  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    plwc_pkg::in_t item;
    logic [plwc_pkg::RefW-1:0] ref_settings[5];
    int unsigned k;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed table at the reset reference of 26 MHz.
    row = '{default: '0};
    // Frequency too high: band 0, words from divider 6, flagged.
    row.freq = 30'h3FFFFFFF; row.shift = 16'hFFFF; rows.push_back(row);
    row.freq = plwc_pkg::FreqLimitB1;  row.shift = 16'd0;    rows.push_back(row);
    row.freq = plwc_pkg::FreqLimitB1 - 1; row.shift = 16'd2600; rows.push_back(row);
    // Every band boundary from both sides.
    row.freq = plwc_pkg::FreqLimitB2;  rows.push_back(row);
    row.freq = plwc_pkg::FreqLimitB2 - 1; rows.push_back(row);
    row.freq = plwc_pkg::FreqLimitB3;  rows.push_back(row);
    row.freq = plwc_pkg::FreqLimitB3 - 1; rows.push_back(row);
    row.freq = plwc_pkg::FreqLimitB4;  rows.push_back(row);
    row.freq = plwc_pkg::FreqLimitB4 - 1; rows.push_back(row);
    row.freq = plwc_pkg::FreqLimitB5;  rows.push_back(row);
    row.freq = plwc_pkg::FreqLimitB5 - 1; rows.push_back(row);
    row.freq = 30'd434000000; row.shift = 16'd1; rows.push_back(row);
    row.freq = 30'd144800000; row.shift = 16'hFFFF; rows.push_back(row);
    // Divider underflow: a frequency of zero gives a zero divider with the flag.
    row.freq = 30'd0; row.shift = 16'd0; row.has_known = 1'b1;
    row.known = '{band_word: 4'd13, integer_divider: 8'd0, frac_word: 20'd0,
                  channel_step: 16'd0, deviation_word: 24'd629, out_of_range: 1'b1};
    rows.push_back(row);
    row.has_known = 1'b0;
    row.freq = 30'd2166666; rows.push_back(row);
    row.freq = 30'd2166667; rows.push_back(row);
    foreach (rows[i]) begin
      item.freq_hz = rows[i].freq;
      item.shift_hz = rows[i].shift;
      send_checked(item, 1'b1, rows[i].has_known, rows[i].known);
    end
    drain_and_settle();

    // Reference too small for a nonzero pfd: band word set, rest zero, flagged.
    write_ref('0);
    item.freq_hz = 30'd434000000; item.shift_hz = 16'd100;
    send_checked(item, 1'b0, 1'b1, '{band_word: 4'd10, integer_divider: 8'd0,
                 frac_word: 20'd0, channel_step: 16'd0, deviation_word: 24'd0,
                 out_of_range: 1'b1});
    drain_and_settle();
    // Small reference: large divider overflow and word saturation.
    write_ref(25'd12);
    item.freq_hz = 30'd100000000; item.shift_hz = 16'hFFFF;
    send_checked(item, 1'b0, 1'b0, '0);
    item.freq_hz = 30'd1; send_checked(item, 1'b0, 1'b0, '0);
    drain_and_settle();

    // Random phases across several references, the extremes among them.
    ref_settings = '{25'd10000000, 25'd32000000, 25'h1FFFFFF, 25'd26000000, 25'd19200000};
    for (int unsigned p = 0; p < 5; p++) begin
      write_ref(ref_settings[p]);
      if (p == 1) begin
        // Long receiver hold-off while requests keep coming, so the pipe fills.
        rx_hold_cycles = 300;
      end
      rx_calm = (p == 3);
      for (k = 0; k < RandomItems / 5; k++) begin
        send_checked(random_request(), !rx_calm, 1'b0, '0);
        // Once per phase, stop sending until everything is back.
        if (k == 100) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (tuning_words_q.size() != 0) @(posedge clk_i);
        end
      end
      rx_calm = 1'b0;
      drain_and_settle();
    end
    // Random references between phases of a few items each.
    repeat (6) begin
      write_ref(plwc_pkg::RefW'($urandom_range(32000000, 10000000)));
      repeat (20) send_checked(random_request(), 1'b1, 1'b0, '0);
      drain_and_settle();
    end

    if (mismatches == 0 && tuning_words_q.size() == 0) begin
      $display("fractional_n_pll_word_calc_core regression: pass");
    end else begin
      $display("fractional_n_pll_word_calc_core regression: fail");
    end
    $finish;
  end

endmodule
